// ===== design/wma_pkg.sv =====
// ----------------------------------------------------------------------------
// Windowed moving average package
// Shared field widths, register reset value and divider status type.
// ----------------------------------------------------------------------------
package wma_pkg;

    localparam int SAMPLE_W     = 12;
    localparam int AVG_W        = 13;
    localparam int OFFSET_W     = 8;
    localparam logic [OFFSET_W-1:0] OFFSET_RESET = 8'd100;

    typedef struct packed {
        logic done;
        logic rem_nonzero;
    } div_status_t;

endpackage

// ===== design/windowed_moving_average_unit.sv =====
// ----------------------------------------------------------------------------
// Windowed moving average unit
// Ring of recent samples with running sum; reports floor(sum/count) + offset.
// ----------------------------------------------------------------------------
// An accepted sample passes through update, divider start, divide and finish before
// the average is valid; the next sample is taken only after the unit returns to idle.
// The bit-serial divider yields one quotient bit per cycle; MAG_W = 12 + clog2(WINDOW_LEN).
// Reset clears sum, count, write pointer and output valid; offset returns to 100.
// Window memory contents are not reset; a slot's read data is used only after it is written.
module windowed_moving_average_unit #(
    parameter int WINDOW_LEN = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                sample_valid,
    output logic                                sample_stall,
    input  logic signed [wma_pkg::SAMPLE_W-1:0] sample,
    output logic                                average_valid,
    input  logic                                average_stall,
    output logic signed [wma_pkg::AVG_W-1:0]    average_out,
    input  logic                                offset_write_en,
    input  logic [wma_pkg::OFFSET_W-1:0]        offset_write_data
);
    import wma_pkg::*;

    localparam int PTR_W   = $clog2(WINDOW_LEN);
    localparam int COUNT_W = $clog2(WINDOW_LEN + 1);
    localparam int SUM_W   = SAMPLE_W + $clog2(WINDOW_LEN) + 1;
    localparam int MAG_W   = SUM_W - 1;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_UPDATE = 5'b00010,
        S_START  = 5'b00100,
        S_DIVIDE = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

    state_t                     state_reg, state_next;
    logic signed [SUM_W-1:0]    sum_reg, sum_next;
    logic [COUNT_W-1:0]         count_reg, count_next;
    logic [PTR_W-1:0]           ptr_reg, ptr_next;
    logic [OFFSET_W-1:0]        offset_reg;
    logic signed [SAMPLE_W-1:0] sample_reg, sample_next;
    logic signed [SAMPLE_W-1:0] rd_data_reg;
    logic [AVG_W-1:0]           result_reg, result_next;
    logic                       average_valid_reg, average_valid_next;
    logic [AVG_W-1:0]           average_out_reg, average_out_next;
    logic                       mem_we;
    logic                       div_start;
    logic                       window_full;
    logic                       sum_neg;
    logic [SUM_W-1:0]           sum_abs;
    logic [MAG_W-1:0]           div_quotient;
    div_status_t                div_status;
    logic [AVG_W-1:0]           q_low;
    logic [AVG_W-1:0]           q_up;
    logic [AVG_W-1:0]           avg_floor;

    logic signed [SAMPLE_W-1:0] window_mem [WINDOW_LEN];

    assign window_full = (count_reg == COUNT_W'(WINDOW_LEN));
    assign sum_neg     = sum_reg[SUM_W-1];
    assign sum_abs     = sum_neg ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);

    assign q_low     = div_quotient[AVG_W-1:0];
    assign q_up      = q_low + AVG_W'(div_status.rem_nonzero);
    assign avg_floor = sum_neg ? AVG_W'(-q_up) : q_low;

    wma_div #(
        .MAG_W (MAG_W),
        .DEN_W (COUNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_abs[MAG_W-1:0]),
        .divisor  (count_reg),
        .quotient (div_quotient),
        .status   (div_status)
    );

    always_comb
    begin
        state_next         = state_reg;
        sum_next           = sum_reg;
        count_next         = count_reg;
        ptr_next           = ptr_reg;
        sample_next        = sample_reg;
        result_next        = result_reg;
        average_valid_next = average_valid_reg;
        average_out_next   = average_out_reg;
        mem_we             = 1'b0;
        div_start          = 1'b0;

        if (average_valid_reg && !average_stall)
        begin
            average_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (sample_valid)
                begin
                    sample_next = sample;
                    state_next  = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                mem_we = 1'b1;
                if (window_full)
                begin
                    sum_next = sum_reg + SUM_W'(sample_reg) - SUM_W'(rd_data_reg);
                end
                else
                begin
                    sum_next   = sum_reg + SUM_W'(sample_reg);
                    count_next = count_reg + COUNT_W'(1);
                end
                ptr_next   = (ptr_reg == PTR_W'(WINDOW_LEN - 1)) ? '0 : ptr_reg + PTR_W'(1);
                state_next = S_START;
            end
            S_START:
            begin
                div_start  = 1'b1;
                state_next = S_DIVIDE;
            end
            S_DIVIDE:
            begin
                if (div_status.done)
                begin
                    result_next = avg_floor + AVG_W'(offset_reg);
                    state_next  = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!average_valid_reg || !average_stall)
                begin
                    average_valid_next = 1'b1;
                    average_out_next   = result_reg;
                    state_next         = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            sum_reg           <= '0;
            count_reg         <= '0;
            ptr_reg           <= '0;
            offset_reg        <= OFFSET_RESET;
            average_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            sum_reg           <= sum_next;
            count_reg         <= count_next;
            ptr_reg           <= ptr_next;
            average_valid_reg <= average_valid_next;
            if (offset_write_en)
            begin
                offset_reg <= offset_write_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg      <= sample_next;
        result_reg      <= result_next;
        average_out_reg <= average_out_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            window_mem[ptr_reg] <= sample_reg;
        end
        rd_data_reg <= window_mem[ptr_reg];
    end

    assign sample_stall  = (state_reg != S_IDLE);
    assign average_valid = average_valid_reg;
    assign average_out   = average_out_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && !sample_stall |=> state_reg == S_UPDATE)
        else $error("accepted item did not enter update");

    assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> count_reg != '0)
        else $error("divide started with zero count");

    assert property (@(posedge clk) disable iff (!rst_n)
        div_status.done |-> state_reg == S_DIVIDE)
        else $error("divider finished outside divide state");

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(WINDOW_LEN))
        else $error("sample count beyond window length");

endmodule

// ===== design/wma_div.sv =====
// ----------------------------------------------------------------------------
// Windowed moving average divider
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wma_div #(
    parameter int MAG_W = 17,
    parameter int DEN_W = 6
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [MAG_W-1:0]     dividend,
    input  logic [DEN_W-1:0]     divisor,
    output logic [MAG_W-1:0]     quotient,
    output wma_pkg::div_status_t status
);
    import wma_pkg::*;

    localparam int STEP_W = $clog2(MAG_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [MAG_W-1:0]  acc_reg, acc_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              fits;

    assign trial = {rem_reg, acc_reg[MAG_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = (trial >= {1'b0, den_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(MAG_W);
            acc_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
        end
        else if (busy_reg)
        begin
            acc_next  = {acc_reg[MAG_W-2:0], fits};
            rem_next  = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign quotient           = acc_reg;
    assign status.done        = done_reg;
    assign status.rem_nonzero = |rem_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg && !done_reg)
        else $error("divider not busy after start");

    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg && $past(busy_reg))
        else $error("divider done without a finished run");

    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> step_reg != '0)
        else $error("divider busy with no steps left");

endmodule
